### hw/rtl/xs64_pkg.sv
// Shared types, constants and helper functions for the xorshift64* generator.
package xs64_pkg;

    typedef logic [63:0] word_t;
    typedef logic [31:0] half_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    localparam word_t MIX_MUL1      = 64'hBF58476D1CE4E5B9;
    localparam word_t MIX_MUL2      = 64'h94D049BB133111EB;
    localparam word_t STAR_MUL      = 64'h2545F4914F6CDD1D;
    localparam word_t GOLDEN_WORD   = 64'h9E3779B97F4A7C15;
    localparam half_t ALL_ONES32    = 32'hFFFFFFFF;
    localparam word_t GOLDEN_PREMIX = GOLDEN_WORD ^ (GOLDEN_WORD >> 30);

    localparam int MUL_DIGIT = 2;
    localparam int MUL_STEPS = 64 / MUL_DIGIT;
    localparam int DIV_STEPS = 32;

    localparam logic [1:0] KIND_FULL    = 2'd0;
    localparam logic [1:0] KIND_UPPER   = 2'd1;
    localparam logic [1:0] KIND_BOUNDED = 2'd2;

    function automatic word_t premix(input word_t s);
        return s ^ (s >> 30);
    endfunction

    function automatic word_t xorshift(input word_t w);
        word_t x;
        x = w ^ (w >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

endpackage

### hw/rtl/xs64_mul.sv
// Digit-serial 64 x 64 multiplier returning the low 64 bits, two bits per cycle.
module xs64_mul
    import xs64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  word_t        operand,
    input  word_t        multiplier,
    output unit_status_t status,
    output word_t        product
);

    localparam int CNT_W = $clog2(MUL_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MUL_STEPS - 1);

    word_t            a_reg, a_next;
    word_t            a3_reg, a3_next;
    word_t            b_reg, b_next;
    word_t            acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    word_t            partial;

    always_comb
    begin
        case (b_reg[1:0])
            2'd0:    partial = '0;
            2'd1:    partial = a_reg;
            2'd2:    partial = {a_reg[62:0], 1'b0};
            default: partial = a3_reg;
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        a3_next   = a3_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = operand;
            a3_next  = operand + {operand[62:0], 1'b0};
            b_next   = multiplier;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + partial;
            a_next   = a_reg << MUL_DIGIT;
            a3_next  = a3_reg << MUL_DIGIT;
            b_next   = b_reg >> MUL_DIGIT;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        a3_reg  <= a3_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

### hw/rtl/xs64_div.sv
// Bit-serial restoring divider giving the 32-bit remainder, one bit per cycle.
module xs64_div
    import xs64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  half_t        dividend,
    input  half_t        divisor,
    output unit_status_t status,
    output half_t        remainder
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    half_t            dvd_reg, dvd_next;
    half_t            dvs_reg, dvs_next;
    half_t            rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [32:0]      shifted;
    logic [32:0]      diff;

    assign shifted = {rem_reg, dvd_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = diff[32] ? shifted[31:0] : diff[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

### hw/rtl/xorshift64_star_generator.sv
// Top level of the xorshift64* generator: APB seed register, sequencer and output register.
// Kinds 0 and 1: one draw through the 2-bit-per-cycle multiplier, then the output register.
// Kind 2: divider computes the rejection limit, draws repeat until one is below it, divider
// then gives the remainder. Bound 0 (kind 2) and kind 3: result 0. One item in flight; the
// next is accepted the cycle after its result is registered, even while it waits downstream.
// Reset and each seed write run a mixing pass, no transactions; seed resets to 0.
module xorshift64_star_generator
    import xs64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] bound
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] value
);

    localparam logic [3:0] ST_MIX1    = 4'd0;
    localparam logic [3:0] ST_MIX1_W  = 4'd1;
    localparam logic [3:0] ST_MIX2    = 4'd2;
    localparam logic [3:0] ST_MIX2_W  = 4'd3;
    localparam logic [3:0] ST_IDLE    = 4'd4;
    localparam logic [3:0] ST_LIMIT_W = 4'd5;
    localparam logic [3:0] ST_DRAW    = 4'd6;
    localparam logic [3:0] ST_DRAW_W  = 4'd7;
    localparam logic [3:0] ST_MOD_W   = 4'd8;
    localparam logic [3:0] ST_WRITE   = 4'd9;

    logic [3:0]   state_reg, state_next;
    word_t        seed_reg, seed_next;
    word_t        gen_reg, gen_next;
    word_t        z_reg, z_next;
    logic [1:0]   kind_reg, kind_next;
    half_t        bound_reg, bound_next;
    half_t        limit_reg, limit_next;
    word_t        result_reg, result_next;
    logic         m_valid_reg, m_valid_next;
    word_t        m_data_reg, m_data_next;

    logic         mul_start;
    word_t        mul_operand;
    word_t        mul_const;
    word_t        mul_product;
    unit_status_t mul_stat;
    logic         div_start;
    half_t        div_dividend;
    half_t        div_divisor;
    half_t        div_rem;
    unit_status_t div_stat;

    word_t        drawn;
    word_t        mixed;
    logic         cfg_write;
    logic         accept;

    assign drawn     = xorshift(gen_reg);
    assign mixed     = mul_product ^ (mul_product >> 31);
    assign cfg_write = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    xs64_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start),
        .operand    (mul_operand),
        .multiplier (mul_const),
        .status     (mul_stat),
        .product    (mul_product)
    );

    xs64_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        seed_next    = seed_reg;
        gen_next     = gen_reg;
        z_next       = z_reg;
        kind_next    = kind_reg;
        bound_next   = bound_reg;
        limit_next   = limit_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mul_start    = 1'b0;
        mul_operand  = z_reg;
        mul_const    = MIX_MUL1;
        div_start    = 1'b0;
        div_dividend = ALL_ONES32;
        div_divisor  = s_tdata;

        case (state_reg)
            ST_MIX1:
            begin
                mul_start  = 1'b1;
                state_next = ST_MIX1_W;
            end
            ST_MIX1_W:
            begin
                if (mul_stat.done)
                begin
                    z_next     = mul_product ^ (mul_product >> 27);
                    state_next = ST_MIX2;
                end
            end
            ST_MIX2:
            begin
                mul_start  = 1'b1;
                mul_const  = MIX_MUL2;
                state_next = ST_MIX2_W;
            end
            ST_MIX2_W:
            begin
                if (mul_stat.done)
                begin
                    gen_next   = (mixed == '0) ? GOLDEN_WORD : mixed;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = s_tuser;
                    bound_next = s_tdata;
                    if (s_tuser inside {KIND_FULL, KIND_UPPER})
                    begin
                        state_next = ST_DRAW;
                    end
                    else if (s_tuser == KIND_BOUNDED && s_tdata != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_LIMIT_W;
                    end
                    else
                    begin
                        result_next = '0;
                        state_next  = ST_WRITE;
                    end
                end
            end
            ST_LIMIT_W:
            begin
                if (div_stat.done)
                begin
                    limit_next = ALL_ONES32 - div_rem;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                gen_next    = drawn;
                mul_start   = 1'b1;
                mul_operand = drawn;
                mul_const   = STAR_MUL;
                state_next  = ST_DRAW_W;
            end
            ST_DRAW_W:
            begin
                div_dividend = mul_product[63:32];
                div_divisor  = bound_reg;
                if (mul_stat.done)
                begin
                    if (kind_reg == KIND_FULL)
                    begin
                        result_next = mul_product;
                        state_next  = ST_WRITE;
                    end
                    else if (kind_reg == KIND_UPPER)
                    begin
                        result_next = {32'd0, mul_product[63:32]};
                        state_next  = ST_WRITE;
                    end
                    else if (mul_product[63:32] < limit_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_MOD_W;
                    end
                    else
                    begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_MOD_W:
            begin
                if (div_stat.done)
                begin
                    result_next = {32'd0, div_rem};
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            seed_next  = pwdata;
            z_next     = premix((pwdata == '0) ? GOLDEN_WORD : pwdata);
            state_next = ST_MIX1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_MIX1;
            seed_reg    <= '0;
            gen_reg     <= GOLDEN_WORD;
            z_reg       <= GOLDEN_PREMIX;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seed_reg    <= seed_next;
            gen_reg     <= gen_next;
            z_reg       <= z_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        bound_reg  <= bound_next;
        limit_reg  <= limit_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

    assign prdata   = seed_reg;
    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_idle_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mul_stat.busy)
        else $error("multiplier busy while accepting transactions");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while accepting transactions");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0)
        else $error("generator word reached zero");

    a_mod_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD_W && div_stat.done && !cfg_write) |=> state_reg == ST_WRITE)
        else $error("remainder done without result write");
`endif

endmodule
